// ----- rtl/ftm_pkg.sv -----
// ----------------------------------------------------------------------------
// ftm_pkg
// Shared types and constants of the windowed frame timing monitor.
// ----------------------------------------------------------------------------
package ftm_pkg;

    localparam int RES_W   = 32;
    localparam int DELTA_W = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 32'd1000000;
    localparam logic [CFG_W-1:0] TPS_RESET    = 32'd1000000;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TPS    = 1'b1;

    typedef enum logic [1:0] {
        KIND_BEGIN   = 2'd0,
        KIND_PAUSE   = 2'd1,
        KIND_UNPAUSE = 2'd2,
        KIND_FRAME   = 2'd3
    } t_kind;

    // which quotient the shared divider is working on
    localparam logic [1:0] SEL_FRAME = 2'd0;
    localparam logic [1:0] SEL_BUSY  = 2'd1;
    localparam logic [1:0] SEL_AVG   = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_MUL   = 5'b00100,
        S_DIV   = 5'b01000,
        S_WAIT  = 5'b10000
    } t_seq_state;

endpackage

// ----- rtl/windowed_frame_timing_monitor.sv -----
// ----------------------------------------------------------------------------
// windowed_frame_timing_monitor
// Frame timing statistics over a wall-clock window: frame rate, busy-only
// rate, mean, best and worst busy time.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_in_valid / o_in_stall) takes one event per transaction:
//  kind, wall delta and busy delta. Output channel (o_out_valid / i_out_stall)
//  carries one statistics result when a frame end closes the window.
//  An event that publishes nothing is absorbed straight from idle; a counted
//  frame end also passes through the window check. A publishing frame end then
//  runs one bit-serial multiply and three bit-serial divisions on one shared
//  divider, and o_in_stall is high for the whole publish.
//  The result sits in an output register, so new events are taken while it
//  waits. A stalled receiver only holds up the next publish, which waits
//  with o_in_stall high until the output register is free.
//  Configuration: i_cfg_we writes window (index 0) or ticks per second
//  (index 1) from i_cfg_data; both reset to 1000000.
//  Synchronous reset puts the block in the paused, uninitialised state with
//  a cleared window and no result pending.
// ----------------------------------------------------------------------------
module windowed_frame_timing_monitor #(
    parameter int SUM_WIDTH   = 48,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ftm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ftm_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_kind,
    input  logic [ftm_pkg::DELTA_W-1:0]    i_wall_delta,
    input  logic [ftm_pkg::DELTA_W-1:0]    i_busy_delta,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ftm_pkg::RES_W-1:0]      o_frame_rate,
    output logic [ftm_pkg::RES_W-1:0]      o_busy_rate,
    output logic [ftm_pkg::RES_W-1:0]      o_average_busy,
    output logic [ftm_pkg::RES_W-1:0]      o_best_busy,
    output logic [ftm_pkg::RES_W-1:0]      o_worst_busy
);
    import ftm_pkg::*;

    localparam int PROD_W = COUNT_WIDTH + CFG_W;
    localparam int DIV_W  = (PROD_W > SUM_WIDTH) ? PROD_W : SUM_WIDTH;

    t_seq_state r_state, n_state;
    logic [1:0] r_sel, n_sel;
    logic [CFG_W-1:0] r_window, r_tps;
    logic r_out_valid;
    logic [RES_W-1:0] r_frame_rate, r_busy_rate, r_avg;
    logic [RES_W-1:0] r_o_fr, r_o_br, r_o_avg, r_o_best, r_o_worst;

    t_kind w_kind;
    logic w_acc, w_counted, w_pub, w_clear, w_load;
    logic w_paused;
    logic [SUM_WIDTH-1:0]   w_elapsed, w_busy_sum;
    logic [COUNT_WIDTH-1:0] w_count;
    logic [RES_W-1:0]       w_min, w_max;

    logic               w_mul_start, w_mul_done;
    logic [PROD_W-1:0]  w_prod;
    logic               w_div_start, w_div_done;
    logic [1:0]         w_div_sel;
    logic [DIV_W-1:0]   w_div_n;
    logic [SUM_WIDTH-1:0] w_div_d;
    logic [RES_W-1:0]   w_div_q;

    assign w_kind    = t_kind'(i_kind);
    assign w_acc     = i_in_valid && !o_in_stall;
    assign w_counted = w_acc && (w_kind == KIND_FRAME) && !w_paused;
    assign w_pub     = w_elapsed > SUM_WIDTH'(r_window);
    assign w_load    = (r_state == S_WAIT) && (!r_out_valid || !i_out_stall);
    assign w_clear   = w_load;

    ftm_window #(
        .SUM_WIDTH   (SUM_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (w_acc),
        .i_kind        (w_kind),
        .i_wall_delta  (i_wall_delta),
        .i_busy_delta  (i_busy_delta),
        .i_clear       (w_clear),
        .o_paused      (w_paused),
        .o_elapsed_sum (w_elapsed),
        .o_busy_sum    (w_busy_sum),
        .o_frame_count (w_count),
        .o_min_busy    (w_min),
        .o_max_busy    (w_max)
    );

    assign w_mul_start = (r_state == S_CHECK) && w_pub;

    ftm_ser_mul #(
        .A_W (COUNT_WIDTH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_count),
        .i_b     (r_tps),
        .o_done  (w_mul_done),
        .o_p     (w_prod)
    );

    // operands are chosen for the division about to start
    assign w_div_sel   = (r_state == S_MUL) ? SEL_FRAME : 2'(r_sel + 2'd1);
    assign w_div_start = ((r_state == S_MUL) && w_mul_done)
                      || ((r_state == S_DIV) && w_div_done && (r_sel != SEL_AVG));

    always_comb begin
        case (w_div_sel)
            SEL_FRAME: begin
                w_div_n = DIV_W'(w_prod);
                w_div_d = w_elapsed;
            end
            SEL_BUSY: begin
                w_div_n = DIV_W'(w_prod);
                w_div_d = w_busy_sum;
            end
            SEL_AVG: begin
                w_div_n = DIV_W'(w_busy_sum);
                w_div_d = SUM_WIDTH'(w_count);
            end
            default: begin
                w_div_n = '0;
                w_div_d = '0;
            end
        endcase
    end

    ftm_ser_div #(
        .N_W (DIV_W),
        .D_W (SUM_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_n     (w_div_n),
        .i_d     (w_div_d),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        case (r_state)
            S_IDLE: begin
                if (w_counted) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = w_pub ? S_MUL : S_IDLE;
            end
            S_MUL: begin
                if (w_mul_done) begin
                    n_state = S_DIV;
                    n_sel   = SEL_FRAME;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (r_sel == SEL_AVG) begin
                        n_state = S_WAIT;
                    end else begin
                        n_sel = 2'(r_sel + 2'd1);
                    end
                end
            end
            S_WAIT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= SEL_FRAME;
            r_window    <= WINDOW_RESET;
            r_tps       <= TPS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW: r_window <= i_cfg_data;
                    CFG_TPS:    r_tps    <= i_cfg_data;
                    default:    r_window <= r_window;
                endcase
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DIV) && w_div_done) begin
            case (r_sel)
                SEL_FRAME: r_frame_rate <= w_div_q;
                SEL_BUSY:  r_busy_rate  <= w_div_q;
                SEL_AVG:   r_avg        <= w_div_q;
                default:   r_avg        <= r_avg;
            endcase
        end
        if (w_load) begin
            r_o_fr    <= r_frame_rate;
            r_o_br    <= r_busy_rate;
            r_o_avg   <= r_avg;
            r_o_best  <= w_min;
            r_o_worst <= w_max;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_frame_rate   = r_o_fr;
    assign o_busy_rate    = r_o_br;
    assign o_average_busy = r_o_avg;
    assign o_best_busy    = r_o_best;
    assign o_worst_busy   = r_o_worst;

`ifndef SYNTH
    // window check only follows an accepted frame end
    a_check_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> $past(i_in_valid && !o_in_stall && (i_kind == KIND_FRAME)))
        else $error("window check without a frame end transaction");

    // statistics run only once the window has been exceeded
    a_pub_needs_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MUL) && $past(r_state == S_CHECK)) |-> $past(w_pub))
        else $error("publish started inside the window");

    // a new result appears only at the end of the publish sequence
    a_result_from_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_WAIT))
        else $error("result loaded outside the publish sequence");
`endif

endmodule

// ----- rtl/ftm_window.sv -----
// ----------------------------------------------------------------------------
// ftm_window
// Window accumulators: saturating wall and busy sums, frame count,
// smallest and largest busy delta, pause and first-frame tracking.
// ----------------------------------------------------------------------------
module ftm_window #(
    parameter int SUM_WIDTH   = 48,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_acc,
    input  ftm_pkg::t_kind               i_kind,
    input  logic [ftm_pkg::DELTA_W-1:0]  i_wall_delta,
    input  logic [ftm_pkg::DELTA_W-1:0]  i_busy_delta,
    input  logic                         i_clear,
    output logic                         o_paused,
    output logic [SUM_WIDTH-1:0]         o_elapsed_sum,
    output logic [SUM_WIDTH-1:0]         o_busy_sum,
    output logic [COUNT_WIDTH-1:0]       o_frame_count,
    output logic [ftm_pkg::RES_W-1:0]    o_min_busy,
    output logic [ftm_pkg::RES_W-1:0]    o_max_busy
);
    import ftm_pkg::*;

    logic                   r_paused, n_paused;
    logic                   r_init, n_init;
    logic [SUM_WIDTH-1:0]   r_elapsed, n_elapsed;
    logic [SUM_WIDTH-1:0]   r_busy, n_busy;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [RES_W-1:0]       r_min, n_min;
    logic [RES_W-1:0]       r_max, n_max;

    logic [SUM_WIDTH-1:0]   w_base_e, w_base_b;
    logic [COUNT_WIDTH-1:0] w_base_c;
    logic [RES_W-1:0]       w_base_mn, w_base_mx;
    logic [DELTA_W-1:0]     w_wall;

    function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] a,
                                                      input logic [DELTA_W-1:0] b);
        logic [SUM_WIDTH:0] s;
        s = {1'b0, a} + (SUM_WIDTH+1)'(b);
        return s[SUM_WIDTH] ? '1 : s[SUM_WIDTH-1:0];
    endfunction

    always_comb begin
        n_paused  = r_paused;
        n_init    = r_init;
        n_elapsed = r_elapsed;
        n_busy    = r_busy;
        n_count   = r_count;
        n_min     = r_min;
        n_max     = r_max;

        // first frame end starts from a clean window and drops its wall delta
        w_base_e  = r_init ? r_elapsed : '0;
        w_base_b  = r_init ? r_busy : '0;
        w_base_c  = r_init ? r_count : '0;
        w_base_mn = r_init ? r_min : '1;
        w_base_mx = r_init ? r_max : '0;
        w_wall    = r_init ? i_wall_delta : '0;

        if (i_clear) begin
            n_elapsed = '0;
            n_busy    = '0;
            n_count   = '0;
            n_min     = '1;
            n_max     = '0;
        end else if (i_acc) begin
            case (i_kind)
                KIND_BEGIN, KIND_UNPAUSE: begin
                    n_paused = 1'b0;
                end
                KIND_PAUSE: begin
                    if (!r_paused) begin
                        n_elapsed = sat_add(r_elapsed, i_wall_delta);
                        n_busy    = sat_add(r_busy, i_busy_delta);
                        n_paused  = 1'b1;
                    end
                end
                KIND_FRAME: begin
                    if (!r_paused) begin
                        n_init    = 1'b1;
                        n_elapsed = sat_add(w_base_e, w_wall);
                        n_busy    = sat_add(w_base_b, i_busy_delta);
                        n_min     = (i_busy_delta < w_base_mn) ? i_busy_delta : w_base_mn;
                        n_max     = (i_busy_delta > w_base_mx) ? i_busy_delta : w_base_mx;
                        n_count   = (&w_base_c) ? w_base_c
                                                : COUNT_WIDTH'(w_base_c + 1'b1);
                    end
                end
                default: begin
                    n_paused = r_paused;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paused  <= 1'b1;
            r_init    <= 1'b0;
            r_elapsed <= '0;
            r_busy    <= '0;
            r_count   <= '0;
            r_min     <= '1;
            r_max     <= '0;
        end else begin
            r_paused  <= n_paused;
            r_init    <= n_init;
            r_elapsed <= n_elapsed;
            r_busy    <= n_busy;
            r_count   <= n_count;
            r_min     <= n_min;
            r_max     <= n_max;
        end
    end

    assign o_paused      = r_paused;
    assign o_elapsed_sum = r_elapsed;
    assign o_busy_sum    = r_busy;
    assign o_frame_count = r_count;
    assign o_min_busy    = r_min;
    assign o_max_busy    = r_max;

endmodule

// ----- rtl/ftm_ser_mul.sv -----
// ----------------------------------------------------------------------------
// ftm_ser_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle,
// most significant bit first.
// ----------------------------------------------------------------------------
module ftm_ser_mul #(
    parameter int A_W = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [A_W-1:0]                i_a,
    input  logic [ftm_pkg::CFG_W-1:0]     i_b,
    output logic                          o_done,
    output logic [A_W+ftm_pkg::CFG_W-1:0] o_p
);
    import ftm_pkg::*;

    localparam int P_W   = A_W + CFG_W;
    localparam int CNT_W = $clog2(A_W);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [A_W-1:0]   r_a;
    logic [CFG_W-1:0] r_b;
    logic [P_W-1:0]   r_acc;
    logic [P_W-1:0]   w_acc_nxt;

    assign w_acc_nxt = {r_acc[P_W-2:0], 1'b0} + (r_a[A_W-1] ? P_W'(r_b) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
                if (r_cnt == CNT_W'(A_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_a   <= {r_a[A_W-2:0], 1'b0};
            r_acc <= w_acc_nxt;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

// ----- rtl/ftm_ser_div.sv -----
// ----------------------------------------------------------------------------
// ftm_ser_div
// Bit-serial restoring divider, one quotient bit per cycle, with
// round-half-up, 32-bit saturation and zero result on a zero divisor.
// ----------------------------------------------------------------------------
module ftm_ser_div #(
    parameter int N_W = 48,
    parameter int D_W = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [N_W-1:0]             i_n,
    input  logic [D_W-1:0]             i_d,
    output logic                       o_done,
    output logic [ftm_pkg::RES_W-1:0]  o_q
);
    import ftm_pkg::*;

    localparam int CNT_W = $clog2(N_W);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [N_W-1:0]   r_n;     // dividend shifts out, quotient shifts in
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_d;

    logic [D_W:0]     w_rem_sh, w_diff;
    logic             w_ge;
    logic             w_inc, w_sat;
    logic [RES_W-1:0] w_lo;

    assign w_rem_sh = {r_rem, r_n[N_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_d};
    assign w_diff   = w_rem_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
                if (r_cnt == CNT_W'(N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_d   <= i_d;
            r_rem <= '0;
        end else if (r_busy) begin
            r_n   <= {r_n[N_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[D_W-1:0] : w_rem_sh[D_W-1:0];
        end
    end

    // round up when twice the remainder reaches the divisor
    assign w_inc = {r_rem, 1'b0} >= {1'b0, r_d};
    assign w_lo  = r_n[RES_W-1:0];
    assign w_sat = (|r_n[N_W-1:RES_W]) || (w_inc && (&w_lo));

    always_comb begin
        if (r_d == '0) begin
            o_q = '0;
        end else if (w_sat) begin
            o_q = '1;
        end else begin
            o_q = RES_W'(w_lo + RES_W'(w_inc));
        end
    end

    assign o_done = r_done;

endmodule

// ----- test/tb_windowed_frame_timing_monitor.sv -----
// ----------------------------------------------------------------------------
// tb_windowed_frame_timing_monitor
// Self-checking bench for the frame timing monitor. A predictor in a small
// scoreboard class follows every accepted event and queues the statistics
// each publishing frame end should produce; results are compared field by
// field as they leave the block. Directed events, random traffic over several
// window and rate settings, and a back-to-back run with no idling on either
// side. Both handshakes idle and stall at random elsewhere.
// ----------------------------------------------------------------------------
module tb_windowed_frame_timing_monitor;
    import ftm_pkg::*;

    localparam int SUM_W = 48;
    localparam int CNT_W = 16;
    localparam longint unsigned SUM_MAX   = (64'd1 << SUM_W) - 1;
    localparam longint unsigned COUNT_MAX = (64'd1 << CNT_W) - 1;
    localparam int IDLE_PCT = 34;
    localparam int QUIET_CYCLES = 250;
    localparam int DRAIN_LIMIT  = 50000;

    typedef struct packed {
        logic [RES_W-1:0] frame_rate;
        logic [RES_W-1:0] busy_rate;
        logic [RES_W-1:0] average_busy;
        logic [RES_W-1:0] best_busy;
        logic [RES_W-1:0] worst_busy;
    } t_stats;

    class frame_stats_tracker;
        bit [CFG_W-1:0] window_ticks;
        bit [CFG_W-1:0] ticks_per_sec;
        bit paused;
        bit initialised;
        longint unsigned elapsed_acc;
        longint unsigned busy_acc;
        longint unsigned frames;
        bit [31:0] busy_min;
        bit [31:0] busy_max;
        t_stats due_stats[$];
        int unsigned effective;
        int unsigned published;
        int unsigned checked;
        int unsigned errors;

        function new();
            window_ticks  = WINDOW_RESET;
            ticks_per_sec = TPS_RESET;
            paused        = 1'b1;
            initialised   = 1'b0;
            clear_window();
        endfunction

        function void clear_window();
            elapsed_acc = 0;
            busy_acc    = 0;
            frames      = 0;
            busy_min    = '1;
            busy_max    = '0;
        endfunction

        function void write_register(bit [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] data);
            case (idx)
                CFG_WINDOW: window_ticks = data;
                CFG_TPS:    ticks_per_sec = data;
                default: ;
            endcase
        endfunction

        function longint unsigned add_sat(longint unsigned acc, bit [31:0] delta);
            longint unsigned s;
            s = acc + delta;
            return (s > SUM_MAX) ? SUM_MAX : s;
        endfunction

        // nearest, halves up, clipped to 32 bits
        function bit [31:0] round_div(longint unsigned n, longint unsigned d);
            longint unsigned q;
            longint unsigned r;
            if (d == 0) return '0;
            q = n / d;
            r = n % d;
            if (r != 0 && r >= d - r) q++;
            return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        endfunction

        function void note_event(t_kind kind, bit [31:0] wall, bit [31:0] busy);
            longint unsigned scaled;
            t_stats s;
            case (kind)
                KIND_BEGIN, KIND_UNPAUSE: begin
                    if (paused) effective++;
                    paused = 1'b0;
                end
                KIND_PAUSE: begin
                    if (!paused) begin
                        effective++;
                        elapsed_acc = add_sat(elapsed_acc, wall);
                        busy_acc    = add_sat(busy_acc, busy);
                        paused      = 1'b1;
                    end
                end
                KIND_FRAME: begin
                    if (paused) return;
                    effective++;
                    // first frame end opens a fresh window and drops its wall delta
                    if (!initialised) begin
                        clear_window();
                        initialised = 1'b1;
                        wall = '0;
                    end
                    elapsed_acc = add_sat(elapsed_acc, wall);
                    busy_acc    = add_sat(busy_acc, busy);
                    if (busy < busy_min) busy_min = busy;
                    if (busy > busy_max) busy_max = busy;
                    if (frames < COUNT_MAX) frames++;
                    if (elapsed_acc > window_ticks && frames > 0) begin
                        scaled         = frames * {32'd0, ticks_per_sec};
                        s.frame_rate   = round_div(scaled, elapsed_acc);
                        s.busy_rate    = round_div(scaled, busy_acc);
                        s.average_busy = round_div(busy_acc, frames);
                        s.best_busy    = busy_min;
                        s.worst_busy   = busy_max;
                        due_stats.push_back(s);
                        published++;
                        clear_window();
                    end
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_stats(t_stats got);
            t_stats want;
            if (due_stats.size() == 0) begin
                report_mismatch($sformatf("unexpected result, frame rate %0d", got.frame_rate));
                return;
            end
            want = due_stats.pop_front();
            checked++;
            compare_field("frame_rate", got.frame_rate, want.frame_rate);
            compare_field("busy_rate", got.busy_rate, want.busy_rate);
            compare_field("average_busy", got.average_busy, want.average_busy);
            compare_field("best_busy", got.best_busy, want.best_busy);
            compare_field("worst_busy", got.worst_busy, want.worst_busy);
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_kind = '0;
    logic [DELTA_W-1:0]   i_wall_delta = '0;
    logic [DELTA_W-1:0]   i_busy_delta = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [RES_W-1:0]     o_frame_rate;
    logic [RES_W-1:0]     o_busy_rate;
    logic [RES_W-1:0]     o_average_busy;
    logic [RES_W-1:0]     o_best_busy;
    logic [RES_W-1:0]     o_worst_busy;

    frame_stats_tracker tracker;
    bit          in_idle_on = 1'b1;
    bit          out_idle_on = 1'b1;
    int unsigned sent = 0;
    int unsigned settings_used = 1;

    windowed_frame_timing_monitor #(
        .SUM_WIDTH   (SUM_W),
        .COUNT_WIDTH (CNT_W)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_wall_delta   (i_wall_delta),
        .i_busy_delta   (i_busy_delta),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_frame_rate   (o_frame_rate),
        .o_busy_rate    (o_busy_rate),
        .o_average_busy (o_average_busy),
        .o_best_busy    (o_best_busy),
        .o_worst_busy   (o_worst_busy)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_stall <= out_idle_on && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_stats({o_frame_rate, o_busy_rate, o_average_busy,
                                 o_best_busy, o_worst_busy});
    end

    task automatic send_event(t_kind kind, bit [31:0] wall, bit [31:0] busy);
        while (in_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_wall_delta <= wall;
        i_busy_delta <= busy;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_event(kind, wall, busy);
        sent++;
    endtask

    task automatic wait_quiet();
        int unsigned waited;
        waited = 0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.due_stats.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        // a frame end that publishes nothing may still be in the window check
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.write_register(idx, data);
    endtask

    task automatic apply_settings(bit [CFG_W-1:0] window, bit [CFG_W-1:0] tps);
        wait_quiet();
        write_register(CFG_WINDOW, window);
        write_register(CFG_TPS, tps);
        settings_used++;
    endtask

    task automatic random_event();
        t_kind       kind;
        bit [31:0]   wall;
        bit [31:0]   busy;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        // mostly well-formed traffic: resume when paused, frame ends when running
        if (tracker.paused) begin
            if (pick < 45)      kind = KIND_UNPAUSE;
            else if (pick < 85) kind = KIND_BEGIN;
            else if (pick < 93) kind = KIND_FRAME;
            else                kind = KIND_PAUSE;
        end else begin
            if (pick < 78)      kind = KIND_FRAME;
            else if (pick < 88) kind = KIND_PAUSE;
            else if (pick < 94) kind = KIND_UNPAUSE;
            else                kind = KIND_BEGIN;
        end
        case ($urandom_range(0, 9))
            0:       wall = '0;
            1:       wall = '1;
            2, 3, 4: wall = $urandom_range(0, 2000);
            5, 6:    wall = $urandom_range(0, (tracker.window_ticks >> 1) + 3);
            default: wall = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:          busy = '0;
            1:          busy = '1;
            2, 3, 4, 5: busy = $urandom_range(0, 5000);
            default:    busy = $urandom;
        endcase
        send_event(kind, wall, busy);
    endtask

    task automatic run_random_phase(int unsigned n_items, int unsigned n_results);
        int unsigned eff0;
        int unsigned pub0;
        eff0 = tracker.effective;
        pub0 = tracker.published;
        while (tracker.effective - eff0 < n_items || tracker.published - pub0 < n_results)
            random_event();
    endtask

    // back to back, no idling: full-scale busy deltas, then large wall sums
    task automatic run_back_to_back();
        int unsigned pub0;
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        apply_settings('1, $urandom);
        send_event(KIND_BEGIN, '0, '0);
        repeat (30) send_event(KIND_FRAME, '0, '1);
        pub0 = tracker.published;
        while (tracker.published == pub0) send_event(KIND_FRAME, '1, $urandom);
        repeat (15) begin
            send_event(KIND_PAUSE, '1, '1);
            send_event(KIND_UNPAUSE, $urandom, $urandom);
        end
        send_event(KIND_FRAME, 32'd5, 32'd3);
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    initial begin
        tracker = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, at reset settings
        send_event(KIND_FRAME, 32'd100, 32'd100);        // paused: dropped
        send_event(KIND_PAUSE, 32'd100, 32'd100);        // paused: dropped
        send_event(KIND_UNPAUSE, 32'd7, 32'd7);
        send_event(KIND_UNPAUSE, 32'd0, 32'd0);          // already running
        send_event(KIND_BEGIN, '1, '1);
        send_event(KIND_PAUSE, 32'd500, 32'd300);        // wiped by first frame end
        send_event(KIND_BEGIN, 32'd0, 32'd0);
        send_event(KIND_FRAME, '1, 32'd0);               // first frame, wall dropped
        send_event(KIND_FRAME, 32'd400000, '1);
        send_event(KIND_PAUSE, 32'd300000, 32'd1000);
        send_event(KIND_FRAME, 32'd5, 32'd5);            // paused: dropped
        send_event(KIND_UNPAUSE, 32'd0, 32'd0);
        send_event(KIND_FRAME, 32'd300001, 32'd12345);   // just over the window
        send_event(KIND_FRAME, 32'd1000000, 32'd7);      // exactly the window
        send_event(KIND_FRAME, 32'd1, 32'd9);
        send_event(KIND_FRAME, '1, 32'd0);               // zero busy sum
        send_event(KIND_PAUSE, 32'd2000000, 32'd0);      // over window, no publish
        send_event(KIND_BEGIN, 32'd0, 32'd0);
        send_event(KIND_FRAME, 32'd0, 32'd5);
        send_event(KIND_FRAME, 32'hAAAA_AAAA, 32'h5555_5555);
        send_event(KIND_FRAME, 32'h5555_5555, 32'hAAAA_AAAA);

        apply_settings(32'd1000, 32'd1000000);
        run_random_phase(85, 8);
        apply_settings('0, '1);
        run_random_phase(85, 8);
        apply_settings('1, 32'd1);
        run_random_phase(85, 8);
        apply_settings(32'd1, 32'd1);
        run_random_phase(85, 8);
        run_back_to_back();
        apply_settings($urandom_range(1, 5000000), $urandom);
        run_random_phase(85, 8);
        apply_settings($urandom, $urandom);
        run_random_phase(85, 8);

        wait_quiet();
        if (tracker.due_stats.size() != 0)
            tracker.report_mismatch($sformatf("%0d expected results never arrived",
                                              tracker.due_stats.size()));
        $display("Sent %0d events (%0d with effect) over %0d register settings; %0d results checked,",
                 sent, tracker.effective, settings_used, tracker.checked);
        $display("including zero and full-scale windows and a stretch with no idling.");
        if (tracker.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #30000000;
        $display("FAILURE");
        $finish;
    end

endmodule
